/* hdl/laser_scan_shadow_filter_assert.svh */
// assertion macros for the shadow filter, empty in synthesis builds
`ifndef LASER_SCAN_SHADOW_FILTER_ASSERT_SVH
`define LASER_SCAN_SHADOW_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define LSSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LSSF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define LSSF_ASSERT(lbl, prop, msg)
`define LSSF_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* hdl/lssf_pkg.sv */
package lssf_pkg;

  localparam int MAX_POINTS     = 4096;
  localparam int SIDE_LOW_INDEX = 120;
  localparam int IDX_W          = $clog2(MAX_POINTS);

  localparam int RANGE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int SIDE_W    = 12;
  localparam int CFG_IDX_W = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  localparam logic [CFG_W-1:0]  SIN_STEP_RST  = 16'd143;
  localparam logic [CFG_W-1:0]  COS_STEP_RST  = 16'd32767;
  localparam logic [CFG_W-1:0]  TAN_CLOSE_RST = 16'd1817;
  localparam logic [CFG_W-1:0]  TAN_FAR_RST   = 16'd469;
  localparam logic [CFG_W-1:0]  FAR_THR_RST   = 16'd700;
  localparam logic [CFG_W-1:0]  RANGE_MIN_RST = 16'd0;
  localparam logic [CFG_W-1:0]  RANGE_MAX_RST = 16'd65535;
  localparam logic [SIDE_W-1:0] SIDE_HIGH_RST = 12'd420;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIN_STEP  = 3'd0,
    REG_COS_STEP  = 3'd1,
    REG_TAN_CLOSE = 3'd2,
    REG_TAN_FAR   = 3'd3,
    REG_FAR_THR   = 3'd4,
    REG_RANGE_MIN = 3'd5,
    REG_RANGE_MAX = 3'd6,
    REG_SIDE_HIGH = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0]  sin_step;
    logic [CFG_W-1:0]  cos_step;
    logic [CFG_W-1:0]  tan_close;
    logic [CFG_W-1:0]  tan_far;
    logic [CFG_W-1:0]  far_threshold_mm;
    logic [CFG_W-1:0]  range_min_mm;
    logic [CFG_W-1:0]  range_max_mm;
    logic [SIDE_W-1:0] side_high_index;
  } cfg_t;

  // one classified sample on its way from the front to the back
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               no_return;
    logic               scan_end;
    logic [1:0]         held;
    logic               side_fwd;
    logic               side_bwd;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_EMIT_OLD,
    ST_EMIT_MID,
    ST_EMIT_NEW,
    ST_COMMIT
  } back_state_e;

  typedef enum logic [1:0] {
    STEP_COS,
    STEP_SIN,
    STEP_TAN,
    STEP_CMP
  } step_e;

endpackage

/* hdl/lssf_if.sv */
interface lssf_in_if;
  logic                        valid;
  logic                        ready;
  logic [lssf_pkg::RANGE_W-1:0] range_mm;
  logic                        no_return;
  logic                        scan_end;

  modport source (output valid, output range_mm, output no_return, output scan_end,
                  input ready);
  modport sink (input valid, input range_mm, input no_return, input scan_end,
                output ready);
endinterface

interface lssf_out_if;
  logic                        valid;
  logic                        ready;
  logic [lssf_pkg::RANGE_W-1:0] range_out_mm;
  logic                        no_return_out;
  logic                        shadowed;
  logic                        last_out;

  modport source (output valid, output range_out_mm, output no_return_out,
                  output shadowed, output last_out, input ready);
  modport sink (input valid, input range_out_mm, input no_return_out,
                input shadowed, input last_out, output ready);
endinterface

/* hdl/lssf_front.sv */
module lssf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lssf_pkg::cfg_t      cfg_i,
  lssf_in_if.sink             in_ch_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output lssf_pkg::job_t      push_data_o
);

  logic [lssf_pkg::IDX_W-1:0] idx_q, idx_d, idx_prev;
  logic [1:0]                 held_q, held_d;
  logic                       accept;

  assign in_ch_i.ready = push_ready_i;
  assign push_valid_o  = in_ch_i.valid;
  assign accept        = in_ch_i.valid && push_ready_i;

  // backward test runs on the index before this one
  assign idx_prev = (idx_q != '0) ? idx_q - lssf_pkg::IDX_W'(1) : '0;

  always_comb begin
    push_data_o.range_mm  = in_ch_i.range_mm;
    push_data_o.no_return = in_ch_i.no_return;
    push_data_o.scan_end  = in_ch_i.scan_end;
    push_data_o.held      = held_q;
    push_data_o.side_fwd  = (32'(idx_q) < lssf_pkg::SIDE_LOW_INDEX) ||
                            (32'(idx_q) > 32'(cfg_i.side_high_index));
    push_data_o.side_bwd  = (32'(idx_prev) < lssf_pkg::SIDE_LOW_INDEX) ||
                            (32'(idx_prev) > 32'(cfg_i.side_high_index));
  end

  always_comb begin
    idx_d  = idx_q;
    held_d = held_q;
    if (accept) begin
      if (in_ch_i.scan_end) begin
        idx_d  = '0;
        held_d = '0;
      end else begin
        if (!held_q[1]) begin
          held_d = held_q + 2'd1;
        end
        // index saturates on an over-long scan
        if (32'(idx_q) + 32'd1 < lssf_pkg::MAX_POINTS) begin
          idx_d = idx_q + lssf_pkg::IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      held_q <= '0;
    end else begin
      idx_q  <= idx_d;
      held_q <= held_d;
    end
  end

endmodule

/* hdl/lssf_queue.sv */
module lssf_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_valid_i,
  output logic                          push_ready_o,
  input  lssf_pkg::job_t                push_data_i,
  output logic                          pop_valid_o,
  input  logic                          pop_ready_i,
  output lssf_pkg::job_t                pop_data_o,
  output logic [lssf_pkg::QLVL_W-1:0]   level_o
);

  lssf_pkg::job_t                mem_q [lssf_pkg::QDEPTH];
  logic [lssf_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lssf_pkg::QLVL_W-1:0]   level_q;
  logic                          push, pop;

  assign push_ready_o = (level_q != lssf_pkg::QLVL_W'(lssf_pkg::QDEPTH));
  assign pop_valid_o  = (level_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign level_o      = level_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  function automatic logic [lssf_pkg::QPTR_W-1:0] ptr_next(
    input logic [lssf_pkg::QPTR_W-1:0] p
  );
    if (32'(p) == lssf_pkg::QDEPTH - 1) begin
      return '0;
    end
    return p + lssf_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      case ({push, pop})
        2'b10:   level_q <= level_q + lssf_pkg::QLVL_W'(1);
        2'b01:   level_q <= level_q - lssf_pkg::QLVL_W'(1);
        default: level_q <= level_q;
      endcase
    end
  end

endmodule

/* hdl/lssf_back.sv */
module lssf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lssf_pkg::cfg_t      cfg_i,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  lssf_pkg::job_t      pop_data_i,
  lssf_out_if.source          out_ch_o
);

  localparam logic [2:0] MARK_FWD = 3'b110;
  localparam logic [2:0] MARK_BWD = 3'b011;

  lssf_pkg::back_state_e state_q, state_d;
  lssf_pkg::step_e       step_q, step_d;
  lssf_pkg::job_t        job_q;

  // delay line: 0 is the newest held sample
  logic [lssf_pkg::RANGE_W-1:0] d0_q, d1_q;
  logic                         dn0_q, dn1_q;
  logic [1:0]                   pend_q;
  logic [2:0]                   m_q;

  logic [31:0] y_q, y_d;
  logic [47:0] prod_q, mul_p;
  logic [31:0] mul_a;
  logic [15:0] mul_b;

  logic [lssf_pkg::RANGE_W-1:0] r0, r1;
  logic                         side, in_lim, pair_ok, hit, is_bwd;
  logic [lssf_pkg::CFG_W-1:0]   tan_sel;
  logic [32:0]                  a33, b33;

  logic                         out_free, load_out;
  logic [lssf_pkg::RANGE_W-1:0] o_range_d;
  logic                         o_nr_d, o_sh_d, o_last_d;
  logic                         ov_q;

  // operands of the pair under test
  assign is_bwd = (state_q == lssf_pkg::ST_BWD);
  assign r0     = is_bwd ? job_q.range_mm : d0_q;
  assign r1     = is_bwd ? d0_q : job_q.range_mm;
  assign side   = is_bwd ? job_q.side_bwd : job_q.side_fwd;
  assign in_lim = (r1 >= cfg_i.range_min_mm) && (r1 <= cfg_i.range_max_mm);
  assign pair_ok = !job_q.no_return && !dn0_q && in_lim &&
                   (is_bwd ? job_q.held[1] : (job_q.held != 2'd0));
  assign tan_sel = (side && (r1 <= cfg_i.far_threshold_mm)) ? cfg_i.tan_close
                                                            : cfg_i.tan_far;

  // one shared multiplier, 32 by 16
  always_comb begin
    case (step_q)
      lssf_pkg::STEP_COS: begin
        mul_a = 32'(r0);
        mul_b = cfg_i.cos_step;
      end
      lssf_pkg::STEP_SIN: begin
        mul_a = 32'(r0);
        mul_b = cfg_i.sin_step;
      end
      default: begin
        mul_a = prod_q[31:0];
        mul_b = tan_sel;
      end
    endcase
  end
  assign mul_p = 48'(mul_a) * 48'(mul_b);

  // |r1 * 2^15 - r0 * cos|
  assign a33 = {2'b00, r1, 15'd0};
  assign b33 = {1'b0, prod_q[31:0]};
  always_comb begin
    if (a33 >= b33) begin
      y_d = 32'(a33 - b33);
    end else begin
      y_d = 32'(b33 - a33);
    end
  end
  assign hit = (48'({y_q, 8'd0}) > prod_q);

  assign out_free = !ov_q || out_ch_o.ready;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pop_ready_o = 1'b0;
    load_out    = 1'b0;
    o_range_d   = job_q.range_mm;
    o_nr_d      = job_q.no_return;
    o_sh_d      = m_q[2];
    o_last_d    = 1'b1;
    case (state_q)
      lssf_pkg::ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          state_d = lssf_pkg::ST_FWD;
          step_d  = lssf_pkg::STEP_COS;
        end
      end
      lssf_pkg::ST_FWD, lssf_pkg::ST_BWD: begin
        if (!pair_ok || step_q == lssf_pkg::STEP_CMP) begin
          state_d = is_bwd ? lssf_pkg::ST_EMIT_OLD : lssf_pkg::ST_BWD;
          step_d  = lssf_pkg::STEP_COS;
        end else begin
          case (step_q)
            lssf_pkg::STEP_COS: step_d = lssf_pkg::STEP_SIN;
            lssf_pkg::STEP_SIN: step_d = lssf_pkg::STEP_TAN;
            default:            step_d = lssf_pkg::STEP_CMP;
          endcase
        end
      end
      lssf_pkg::ST_EMIT_OLD: begin
        o_range_d = d1_q;
        o_nr_d    = dn1_q;
        o_sh_d    = m_q[0];
        o_last_d  = 1'b0;
        if (!job_q.held[1] || out_free) begin
          load_out = job_q.held[1];
          state_d  = job_q.scan_end ? lssf_pkg::ST_EMIT_MID : lssf_pkg::ST_COMMIT;
        end
      end
      lssf_pkg::ST_EMIT_MID: begin
        o_range_d = d0_q;
        o_nr_d    = dn0_q;
        o_sh_d    = m_q[1];
        o_last_d  = 1'b0;
        if (job_q.held == 2'd0 || out_free) begin
          load_out = (job_q.held != 2'd0);
          state_d  = lssf_pkg::ST_EMIT_NEW;
        end
      end
      lssf_pkg::ST_EMIT_NEW: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = lssf_pkg::ST_COMMIT;
        end
      end
      lssf_pkg::ST_COMMIT: begin
        state_d = lssf_pkg::ST_IDLE;
      end
      default: begin
        state_d = lssf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lssf_pkg::ST_IDLE;
      step_q  <= lssf_pkg::STEP_COS;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // job and arithmetic registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      lssf_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          job_q <= pop_data_i;
          m_q   <= {1'b0, pend_q};
        end
      end
      lssf_pkg::ST_FWD, lssf_pkg::ST_BWD: begin
        if (pair_ok) begin
          case (step_q)
            lssf_pkg::STEP_COS: prod_q <= mul_p;
            lssf_pkg::STEP_SIN: begin
              y_q    <= y_d;
              prod_q <= mul_p;
            end
            lssf_pkg::STEP_TAN: prod_q <= mul_p;
            default: begin
              if (hit) begin
                m_q <= m_q | (is_bwd ? MARK_BWD : MARK_FWD);
              end
            end
          endcase
        end
      end
      default: begin
        m_q <= m_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_q   <= '0;
      d1_q   <= '0;
      dn0_q  <= 1'b0;
      dn1_q  <= 1'b0;
      pend_q <= '0;
    end else if (state_q == lssf_pkg::ST_COMMIT) begin
      if (job_q.scan_end) begin
        d0_q   <= '0;
        d1_q   <= '0;
        dn0_q  <= 1'b0;
        dn1_q  <= 1'b0;
        pend_q <= '0;
      end else begin
        d1_q   <= d0_q;
        dn1_q  <= dn0_q;
        d0_q   <= job_q.range_mm;
        dn0_q  <= job_q.no_return;
        pend_q <= m_q[2:1];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (load_out) begin
      ov_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ch_o.range_out_mm  <= o_range_d;
      out_ch_o.no_return_out <= o_nr_d;
      out_ch_o.shadowed      <= o_sh_d;
      out_ch_o.last_out      <= o_last_d;
    end
  end

  assign out_ch_o.valid = ov_q;

endmodule

/* hdl/laser_scan_shadow_filter.sv */
// laser scan shadow filter
// in_ch_i takes one range sample per transaction (range_mm, no_return,
// scan_end); out_ch_o gives the filtered samples with a shadowed flag.
// a sample comes out two samples after it went in; the transaction that
// carries scan_end flushes every held sample, oldest first, and the last
// result has last_out set
// the front keeps the scan index and classifies samples into a two-entry
// queue; the back runs the pair tests on one shared 32x16 multiplier,
// in the steps cos, sin, tan and compare; a test that cannot hit ends
// after its first step
// the back takes a new sample only from idle, after the last one is
// committed; the queue can take samples meanwhile
// a stalled receiver holds the output register; the back then waits and
// the queue fills before in_ch_i.ready drops
// reset clears the delay line, marks and index and loads the register
// defaults; cfg_we_i writes register cfg_idx_i; the user must write it
// only while the block idles, which the block itself does not enforce
`include "laser_scan_shadow_filter_assert.svh"

module laser_scan_shadow_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  lssf_in_if.sink                          in_ch_i,
  lssf_out_if.source                       out_ch_o,
  input  logic                             cfg_we_i,
  input  logic [lssf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lssf_pkg::CFG_W-1:0]       cfg_data_i
);

  lssf_pkg::cfg_t                 cfg_q;
  lssf_pkg::job_t                 push_data, pop_data;
  logic                           push_valid, push_ready, pop_valid, pop_ready;
  logic [lssf_pkg::QLVL_W-1:0]    q_level;
  logic                           q_push, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sin_step         <= lssf_pkg::SIN_STEP_RST;
      cfg_q.cos_step         <= lssf_pkg::COS_STEP_RST;
      cfg_q.tan_close        <= lssf_pkg::TAN_CLOSE_RST;
      cfg_q.tan_far          <= lssf_pkg::TAN_FAR_RST;
      cfg_q.far_threshold_mm <= lssf_pkg::FAR_THR_RST;
      cfg_q.range_min_mm     <= lssf_pkg::RANGE_MIN_RST;
      cfg_q.range_max_mm     <= lssf_pkg::RANGE_MAX_RST;
      cfg_q.side_high_index  <= lssf_pkg::SIDE_HIGH_RST;
    end else if (cfg_we_i) begin
      case (lssf_pkg::cfg_reg_e'(cfg_idx_i))
        lssf_pkg::REG_SIN_STEP:  cfg_q.sin_step         <= cfg_data_i;
        lssf_pkg::REG_COS_STEP:  cfg_q.cos_step         <= cfg_data_i;
        lssf_pkg::REG_TAN_CLOSE: cfg_q.tan_close        <= cfg_data_i;
        lssf_pkg::REG_TAN_FAR:   cfg_q.tan_far          <= cfg_data_i;
        lssf_pkg::REG_FAR_THR:   cfg_q.far_threshold_mm <= cfg_data_i;
        lssf_pkg::REG_RANGE_MIN: cfg_q.range_min_mm     <= cfg_data_i;
        lssf_pkg::REG_RANGE_MAX: cfg_q.range_max_mm     <= cfg_data_i;
        lssf_pkg::REG_SIDE_HIGH:
          cfg_q.side_high_index <= cfg_data_i[lssf_pkg::SIDE_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  lssf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_ch_i      (in_ch_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  lssf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .level_o      (q_level)
  );

  lssf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_ch_o    (out_ch_o)
  );

  assign q_push = push_valid && push_ready;
  assign q_pop  = pop_valid && pop_ready;

  `LSSF_ASSERT(a_q_level_max, q_level <= lssf_pkg::QLVL_W'(lssf_pkg::QDEPTH), "queue overfilled")
  `LSSF_ASSERT(a_in_needs_room, !(in_ch_i.valid && in_ch_i.ready) || (q_level != lssf_pkg::QLVL_W'(lssf_pkg::QDEPTH)), "sample taken with full queue")
  `LSSF_ASSERT(a_pop_needs_data, !q_pop || (q_level != '0), "pop from empty queue")
  `LSSF_ASSERT_NEXT(a_level_up, q_push && !q_pop, q_level == $past(q_level) + lssf_pkg::QLVL_W'(1), "queue level lost a push")

endmodule
